/* design/brf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants for the byte ring FIFO
// Storage depth, field widths, command codes and the controller command word.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DEPTH = 256;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    // fixed field widths
    localparam int CMD_W  = 3;
    localparam int DATA_W = 8;
    localparam int SIZE_W = 9;

    // config port
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;
    localparam logic [ADDR_W-3:0] REG_SIZE_IN_USE = '0;
    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(256);

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_OVWR = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEK      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SKIP      = 3'd4;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch input word, read store at head
        logic exec;     // apply command, load output register
    } brf_cmd_t;

    // ring length: 0 acts as 1, anything above DEPTH acts as DEPTH
    function automatic logic [CNT_W-1:0] ring_len(input logic [SIZE_W-1:0] size);
        logic [CNT_W-1:0] s;
        if (size == '0)
            s = CNT_W'(1);
        else if (32'(size) > 32'(DEPTH))
            s = CNT_W'(DEPTH);
        else
            s = CNT_W'(size);
        return s;
    endfunction

endpackage
`default_nettype wire

/* design/brf_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ctrl: handshake controller
// Accepts one word at a time, sequences the execute step and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module brf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output brf_pkg::brf_cmd_t     dp_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        dp_cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    dp_cmd.capture = 1'b1;
                    state_next     = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    dp_cmd.exec    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // an accepted word always moves to execute
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execute");

    // execute never overwrites a result that is still held
    a_exec_free: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.exec |-> out_free)
        else $error("execute while output register busy");

endmodule
`default_nettype wire

/* design/brf_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_dpath: ring datapath
// Byte store, head index, fill count, input latch and output register.
// ----------------------------------------------------------------------------
module brf_dpath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire brf_pkg::brf_cmd_t             dp_cmd,
    input  wire logic                          cfg_clear,
    input  wire logic [brf_pkg::SIZE_W-1:0]    size_in_use,
    input  wire logic [brf_pkg::CMD_W-1:0]     cmd,
    input  wire logic [brf_pkg::DATA_W-1:0]    data_in,
    input  wire logic [brf_pkg::SIZE_W-1:0]    skip_count,
    output logic [brf_pkg::DATA_W-1:0]         data_out,
    output logic                               data_valid,
    output logic                               accepted,
    output logic [brf_pkg::SIZE_W-1:0]         removed_count,
    output logic [brf_pkg::SIZE_W-1:0]         fill_level
);

    localparam int IDX_W  = brf_pkg::IDX_W;
    localparam int CNT_W  = brf_pkg::CNT_W;
    localparam int SUM_W  = brf_pkg::SUM_W;
    localparam int DATA_W = brf_pkg::DATA_W;
    localparam int SIZE_W = brf_pkg::SIZE_W;

    logic [DATA_W-1:0] store [brf_pkg::DEPTH];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  held_reg, held_next;
    logic [brf_pkg::CMD_W-1:0] cmd_reg;
    logic [DATA_W-1:0] din_reg;
    logic [SIZE_W-1:0] skip_reg;
    logic [DATA_W-1:0] rd_data_reg;

    logic [DATA_W-1:0] dout_reg, dout_next;
    logic              dvalid_reg, dvalid_next;
    logic              acc_reg, acc_next;
    logic [SIZE_W-1:0] removed_reg, removed_next;
    logic [SIZE_W-1:0] fill_reg, fill_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    logic [CNT_W-1:0]  ring_s;
    logic [SUM_W-1:0]  tail_sum, head_inc, skip_sum, rem_w;
    logic [IDX_W-1:0]  tail_idx, head_pop, head_skip;
    logic [CNT_W-1:0]  removed, held_skip;

    assign ring_s = brf_pkg::ring_len(size_in_use);

    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(held_reg);
        tail_idx = (tail_sum >= SUM_W'(ring_s)) ? IDX_W'(tail_sum - SUM_W'(ring_s))
                                                 : IDX_W'(tail_sum);

        head_inc = SUM_W'(head_reg) + SUM_W'(1);
        head_pop = (head_inc >= SUM_W'(ring_s) || held_reg == CNT_W'(1)) ? '0
                                                                          : IDX_W'(head_inc);

        // skip saturates at fill, head wraps once at most
        removed   = (SUM_W'(skip_reg) > SUM_W'(held_reg)) ? held_reg : CNT_W'(skip_reg);
        rem_w     = SUM_W'(removed);
        held_skip = held_reg - removed;
        skip_sum  = SUM_W'(head_reg) + rem_w;
        if (held_skip == '0)
            head_skip = '0;
        else if (skip_sum >= SUM_W'(ring_s))
            head_skip = IDX_W'(skip_sum - SUM_W'(ring_s));
        else
            head_skip = IDX_W'(skip_sum);
    end

    always_comb
    begin
        head_next    = head_reg;
        held_next    = held_reg;
        wr_en        = 1'b0;
        wr_addr      = tail_idx;
        dout_next    = '0;
        dvalid_next  = 1'b0;
        acc_next     = 1'b0;
        removed_next = '0;
        unique case (cmd_reg)
            brf_pkg::CMD_PUSH:
            begin
                if (held_reg < ring_s)
                begin
                    wr_en     = 1'b1;
                    held_next = held_reg + CNT_W'(1);
                    acc_next  = 1'b1;
                end
            end
            brf_pkg::CMD_PUSH_OVWR:
            begin
                wr_en    = 1'b1;
                acc_next = 1'b1;
                if (held_reg >= ring_s)
                begin
                    // full: new byte lands in the dropped head slot
                    wr_addr     = head_reg;
                    head_next   = (head_inc >= SUM_W'(ring_s)) ? '0 : IDX_W'(head_inc);
                    dout_next   = rd_data_reg;
                    dvalid_next = 1'b1;
                end
                else
                begin
                    held_next = held_reg + CNT_W'(1);
                end
            end
            brf_pkg::CMD_POP:
            begin
                if (held_reg != '0)
                begin
                    head_next   = head_pop;
                    held_next   = held_reg - CNT_W'(1);
                    dout_next   = rd_data_reg;
                    dvalid_next = 1'b1;
                end
            end
            brf_pkg::CMD_PEEK:
            begin
                if (held_reg != '0)
                begin
                    dout_next   = rd_data_reg;
                    dvalid_next = 1'b1;
                end
            end
            brf_pkg::CMD_SKIP:
            begin
                head_next    = head_skip;
                held_next    = held_skip;
                removed_next = SIZE_W'(removed);
            end
            default:
            begin
            end
        endcase
        fill_next = SIZE_W'(held_next);
    end

    // store: no reset, registered read of the head at capture
    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
            rd_data_reg <= store[head_reg];
        if (dp_cmd.exec && wr_en)
            store[wr_addr] <= din_reg;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg  <= cmd;
            din_reg  <= data_in;
            skip_reg <= skip_count;
        end
        if (dp_cmd.exec)
        begin
            dout_reg    <= dout_next;
            dvalid_reg  <= dvalid_next;
            acc_reg     <= acc_next;
            removed_reg <= removed_next;
            fill_reg    <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            held_reg <= '0;
        end
        else if (cfg_clear)
        begin
            head_reg <= '0;
            held_reg <= '0;
        end
        else if (dp_cmd.exec)
        begin
            head_reg <= head_next;
            held_reg <= held_next;
        end
    end

    assign data_out      = dout_reg;
    assign data_valid    = dvalid_reg;
    assign accepted      = acc_reg;
    assign removed_count = removed_reg;
    assign fill_level    = fill_reg;

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= ring_s)
        else $error("fill count above ring length");

    a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == '0) |-> (head_reg == '0))
        else $error("head not at zero while empty");

endmodule
`default_nettype wire

/* design/byte_ring_fifo_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_core: circular byte FIFO with overwrite-oldest push
// A word is captured at accept (store read at head) and applied at execute,
// which waits for a free output register; in_stall holds off the next word.
// The output register lets the next word be accepted while a result waits.
// Reset: FIFO empty, head 0, size_in_use 256; store contents left undefined.
// ----------------------------------------------------------------------------
module byte_ring_fifo_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [brf_pkg::CMD_W-1:0]      cmd,
    input  wire logic [brf_pkg::DATA_W-1:0]     data_in,
    input  wire logic [brf_pkg::SIZE_W-1:0]     skip_count,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [brf_pkg::DATA_W-1:0]          data_out,
    output logic                                data_valid,
    output logic                                accepted,
    output logic [brf_pkg::SIZE_W-1:0]          removed_count,
    output logic [brf_pkg::SIZE_W-1:0]          fill_level,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [brf_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [brf_pkg::PDATA_W-1:0]    pwdata,
    output logic [brf_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready
);

    logic [brf_pkg::SIZE_W-1:0] size_reg;
    logic                       size_hit;
    logic                       cfg_clear;
    brf_pkg::brf_cmd_t          dp_cmd;

    assign pready    = 1'b1;
    assign size_hit  = (paddr[brf_pkg::ADDR_W-1:2] == brf_pkg::REG_SIZE_IN_USE);
    assign cfg_clear = psel && penable && pwrite && size_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= brf_pkg::SIZE_RESET;
        else if (cfg_clear)
            size_reg <= pwdata[brf_pkg::SIZE_W-1:0];
    end

    assign prdata = size_hit ? brf_pkg::PDATA_W'(size_reg) : '0;

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd)
    );

    brf_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .cfg_clear     (cfg_clear),
        .size_in_use   (size_reg),
        .cmd           (cmd),
        .data_in       (data_in),
        .skip_count    (skip_count),
        .data_out      (data_out),
        .data_valid    (data_valid),
        .accepted      (accepted),
        .removed_count (removed_count),
        .fill_level    (fill_level)
    );

endmodule
`default_nettype wire
